// File: src/jbpf_pkg.sv
// ----------------------------------------------------------------------------
// jbpf_pkg
// Shared types, constants and helpers for the jitter buffer prebuffer FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package jbpf_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SMP_W      = 16;
    localparam int FRAME_W    = 2 * SMP_W;
    localparam int OUT_W      = 32;
    localparam int LW_W       = 14;
    localparam int FILL_W     = 14;
    localparam int URUN_W     = 32;
    localparam int CMP_W      = (PTR_W > LW_W) ? PTR_W : LW_W;

    localparam logic [LW_W-1:0] LOW_WATER_RESET = LW_W'(2048);

    typedef logic [PTR_W-1:0] ptr_t;

    localparam ptr_t FULL_MARK = PTR_W'(RING_DEPTH - 2);
    localparam ptr_t LAST_PTR  = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_PULL  = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_STOPPED   = 2'd0,
        ST_BUFFERING = 2'd1,
        ST_PLAYING   = 2'd2
    } play_state_t;

    typedef struct packed {
        logic                 wr_en;
        ptr_t                 wr_addr;
        logic [FRAME_W-1:0]   wr_data;
        logic                 rd_en;
        ptr_t                 rd_addr;
    } ring_req_t;

    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        r = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // frames between the pointers, modulo the ring depth
    function automatic ptr_t fill_of(input ptr_t wp, input ptr_t rp);
        logic [PTR_W:0] diff;
        diff = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
                          : ({1'b0, wp} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rp});
        return diff[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/jbpf_ring.sv
// ----------------------------------------------------------------------------
// jbpf_ring
// Frame store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jbpf_ring (
    input  wire logic                           clk,
    input  wire jbpf_pkg::ring_req_t            req,
    output logic [jbpf_pkg::FRAME_W-1:0]        rdata
);

    logic [jbpf_pkg::FRAME_W-1:0] mem [jbpf_pkg::RING_DEPTH];
    logic [jbpf_pkg::FRAME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read data holds while no new read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/jitter_buffer_prebuffer_fifo_top.sv
// ----------------------------------------------------------------------------
// jitter_buffer_prebuffer_fifo_top
// Stereo audio ring FIFO with prebuffering, underrun counting and play state.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_stall is low. On acceptance the
// pointers and play state are updated and the frame store access is issued;
// the ring memory then brings back its registered read data, and an output
// register holds the result until it is taken. Pushes write the frame at the
// write pointer, pulls read the frame at the read pointer; the two never touch
// one entry in the same cycle since a pull only reads when frames are held.
// The frame store has no reset and no clearing pass; start and stop only move
// the pointers.
`default_nettype none

module jitter_buffer_prebuffer_fifo_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                low_water_we,
    input  wire logic [jbpf_pkg::LW_W-1:0]           low_water_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          mode,
    input  wire logic signed [jbpf_pkg::SMP_W-1:0]   sample_left,
    input  wire logic signed [jbpf_pkg::SMP_W-1:0]   sample_right,
    input  wire logic                                is_mono,
    input  wire logic                                frame_end,
    input  wire logic                                block_first,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [jbpf_pkg::OUT_W-1:0]        left_out,
    output logic signed [jbpf_pkg::OUT_W-1:0]        right_out,
    output logic                                     accepted,
    output logic [1:0]                               play_state,
    output logic [jbpf_pkg::FILL_W-1:0]              fill_level,
    output logic [jbpf_pkg::URUN_W-1:0]              underrun_total
);

    // architectural state
    jbpf_pkg::ptr_t                 wp_reg, wp_next;
    jbpf_pkg::ptr_t                 rp_reg, rp_next;
    jbpf_pkg::play_state_t          state_reg, state_next;
    logic [jbpf_pkg::URUN_W-1:0]    urun_reg, urun_next;
    logic                           live_reg, live_next;
    logic [jbpf_pkg::LW_W-1:0]      low_water_reg;

    // stage 1: waiting for read data
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_read_reg, s1_read_next;
    logic                           s1_acc_reg, s1_acc_next;
    jbpf_pkg::play_state_t          s1_state_reg;
    logic [jbpf_pkg::FILL_W-1:0]    s1_fill_reg;
    logic [jbpf_pkg::URUN_W-1:0]    s1_urun_reg;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic [jbpf_pkg::OUT_W-1:0]     left_reg, right_reg;
    logic                           acc_reg;
    jbpf_pkg::play_state_t          pstate_reg;
    logic [jbpf_pkg::FILL_W-1:0]    fill_reg;
    logic [jbpf_pkg::URUN_W-1:0]    urun_out_reg;

    jbpf_pkg::ring_req_t            ring_req;
    logic [jbpf_pkg::FRAME_W-1:0]   ring_rdata;

    logic                           accept;
    logic                           s1_move;
    jbpf_pkg::mode_t                mode_in;
    jbpf_pkg::ptr_t                 fill_cur;
    jbpf_pkg::ptr_t                 fill_inc;
    jbpf_pkg::ptr_t                 fill_after;
    logic                           is_full;
    logic                           ring_empty;
    logic                           live_eff;
    logic                           lw_met;
    logic [jbpf_pkg::SMP_W-1:0]     right_store;

    assign mode_in    = jbpf_pkg::mode_t'(mode);
    assign s1_move    = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && out_valid_reg && out_stall;
    assign accept     = in_valid && !in_stall;

    assign fill_cur   = jbpf_pkg::fill_of(wp_reg, rp_reg);
    assign fill_inc   = fill_cur + jbpf_pkg::PTR_W'(1);
    assign is_full    = fill_cur >= jbpf_pkg::FULL_MARK;
    assign ring_empty = (fill_cur == '0);
    assign live_eff   = block_first ? (state_reg == jbpf_pkg::ST_PLAYING) : live_reg;
    assign lw_met     = jbpf_pkg::CMP_W'(fill_inc) >= jbpf_pkg::CMP_W'(low_water_reg);
    assign right_store = is_mono ? sample_left : sample_right;
    assign fill_after = jbpf_pkg::fill_of(wp_next, rp_next);

    // play state next value
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            unique case (mode_in)
                jbpf_pkg::MODE_PUSH:
                begin
                    if (!is_full && frame_end && lw_met
                        && state_reg == jbpf_pkg::ST_BUFFERING)
                    begin
                        state_next = jbpf_pkg::ST_PLAYING;
                    end
                end
                jbpf_pkg::MODE_PULL:
                begin
                    if (live_eff && ring_empty)
                    begin
                        state_next = jbpf_pkg::ST_BUFFERING;
                    end
                end
                jbpf_pkg::MODE_START: state_next = jbpf_pkg::ST_BUFFERING;
                jbpf_pkg::MODE_STOP:  state_next = jbpf_pkg::ST_STOPPED;
                default:              state_next = state_reg;
            endcase
        end
    end

    // pointers, counters and ring accesses
    always_comb
    begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        urun_next        = urun_reg;
        live_next        = live_reg;
        s1_read_next     = 1'b0;
        s1_acc_next      = 1'b1;
        ring_req         = '0;
        ring_req.wr_addr = wp_reg;
        ring_req.wr_data = {sample_left, right_store};
        ring_req.rd_addr = rp_reg;
        if (accept)
        begin
            unique case (mode_in)
                jbpf_pkg::MODE_PUSH:
                begin
                    if (is_full)
                    begin
                        s1_acc_next = 1'b0;
                    end
                    else
                    begin
                        ring_req.wr_en = 1'b1;
                        wp_next        = jbpf_pkg::ptr_advance(wp_reg);
                    end
                end
                jbpf_pkg::MODE_PULL:
                begin
                    live_next = live_eff;
                    if (live_eff)
                    begin
                        if (ring_empty)
                        begin
                            urun_next = urun_reg + jbpf_pkg::URUN_W'(1);
                        end
                        else
                        begin
                            ring_req.rd_en = 1'b1;
                            s1_read_next   = 1'b1;
                            rp_next        = jbpf_pkg::ptr_advance(rp_reg);
                        end
                    end
                end
                jbpf_pkg::MODE_START:
                begin
                    wp_next   = '0;
                    rp_next   = '0;
                    urun_next = '0;
                    live_next = 1'b0;
                end
                jbpf_pkg::MODE_STOP:
                begin
                    wp_next   = '0;
                    rp_next   = '0;
                    live_next = 1'b0;
                end
                default:
                begin
                    wp_next = wp_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            state_reg     <= jbpf_pkg::ST_STOPPED;
            urun_reg      <= '0;
            live_reg      <= 1'b0;
            low_water_reg <= jbpf_pkg::LOW_WATER_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            state_reg     <= state_next;
            urun_reg      <= urun_next;
            live_reg      <= live_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (low_water_we)
            begin
                low_water_reg <= low_water_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg  <= s1_read_next;
            s1_acc_reg   <= s1_acc_next;
            s1_state_reg <= state_next;
            s1_fill_reg  <= jbpf_pkg::FILL_W'(fill_after);
            s1_urun_reg  <= urun_next;
        end
    end

    // silence unless the request read a frame
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            left_reg     <= s1_read_reg
                            ? {ring_rdata[jbpf_pkg::FRAME_W-1:jbpf_pkg::SMP_W],
                               jbpf_pkg::SMP_W'(0)}
                            : '0;
            right_reg    <= s1_read_reg
                            ? {ring_rdata[jbpf_pkg::SMP_W-1:0], jbpf_pkg::SMP_W'(0)}
                            : '0;
            acc_reg      <= s1_acc_reg;
            pstate_reg   <= s1_state_reg;
            fill_reg     <= s1_fill_reg;
            urun_out_reg <= s1_urun_reg;
        end
    end

    jbpf_ring u_ring (
        .clk   (clk),
        .req   (ring_req),
        .rdata (ring_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign left_out       = left_reg;
    assign right_out      = right_reg;
    assign accepted       = acc_reg;
    assign play_state     = pstate_reg;
    assign fill_level     = fill_reg;
    assign underrun_total = urun_out_reg;

endmodule

`default_nettype wire

// File: src/jbpf_checker.sv
// ----------------------------------------------------------------------------
// jbpf_checker
// Port-level checks for the jitter buffer prebuffer FIFO, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module jbpf_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                low_water_we,
    input  wire logic [jbpf_pkg::LW_W-1:0]           low_water_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic [1:0]                          mode,
    input  wire logic signed [jbpf_pkg::SMP_W-1:0]   sample_left,
    input  wire logic signed [jbpf_pkg::SMP_W-1:0]   sample_right,
    input  wire logic                                is_mono,
    input  wire logic                                frame_end,
    input  wire logic                                block_first,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic signed [jbpf_pkg::OUT_W-1:0]   left_out,
    input  wire logic signed [jbpf_pkg::OUT_W-1:0]   right_out,
    input  wire logic                                accepted,
    input  wire logic [1:0]                          play_state,
    input  wire logic [jbpf_pkg::FILL_W-1:0]         fill_level,
    input  wire logic [jbpf_pkg::URUN_W-1:0]         underrun_total
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_out)
            && $stable(right_out) && $stable(fill_level) && $stable(underrun_total))
        else $error("stalled result changed");

    // every accepted request is followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("result missing after accepted request");

    // refused push carries silence
    a_refused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> left_out == '0 && right_out == '0)
        else $error("refused push gave audio");

    // samples sit in the upper half of the output words
    a_low_half_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_out[jbpf_pkg::SMP_W-1:0] == '0
            && right_out[jbpf_pkg::SMP_W-1:0] == '0)
        else $error("output low half not zero");

    // a silent playing result on an empty ring is never a refused push
    a_playing_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && play_state == jbpf_pkg::ST_PLAYING
            && !(left_out != '0 || right_out != '0)
            && fill_level == '0 |-> accepted)
        else $error("playing state with refused request on empty ring");

endmodule

bind jitter_buffer_prebuffer_fifo_top jbpf_checker u_jbpf_checker (.*);

`default_nettype wire

// File: verif/jbpf_output_checker.sv
// ----------------------------------------------------------------------------
// jbpf_output_checker
// Watches both channels and the low-water port of the jitter buffer. Keeps
// its own copy of the ring, the pointers, the play state and the underrun
// count, works out the response to every accepted request, and compares
// each response the block returns with the oldest one still owed.
// ----------------------------------------------------------------------------
module jbpf_output_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               low_water_we,
    input  logic [jbpf_pkg::LW_W-1:0]          low_water_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [jbpf_pkg::SMP_W-1:0]         sample_left,
    input  logic [jbpf_pkg::SMP_W-1:0]         sample_right,
    input  logic                               is_mono,
    input  logic                               frame_end,
    input  logic                               block_first,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [jbpf_pkg::OUT_W-1:0]         left_out,
    input  logic [jbpf_pkg::OUT_W-1:0]         right_out,
    input  logic                               accepted,
    input  logic [1:0]                         play_state,
    input  logic [jbpf_pkg::FILL_W-1:0]        fill_level,
    input  logic [jbpf_pkg::URUN_W-1:0]        underrun_total,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 frames_played,
    output int                                 underruns_seen,
    output int                                 pushes_refused
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [jbpf_pkg::OUT_W-1:0]  left;
        logic [jbpf_pkg::OUT_W-1:0]  right;
        logic                        taken;
        logic [1:0]                  state;
        logic [jbpf_pkg::FILL_W-1:0] fill;
        logic [jbpf_pkg::URUN_W-1:0] underruns;
    } playout_t;

    logic [jbpf_pkg::FRAME_W-1:0] ring_copy [jbpf_pkg::RING_DEPTH];
    jbpf_pkg::ptr_t               wr_ptr;
    jbpf_pkg::ptr_t               rd_ptr;
    jbpf_pkg::play_state_t        player_state;
    logic [jbpf_pkg::URUN_W-1:0]  underrun_count;
    logic                         block_on;
    logic [jbpf_pkg::LW_W-1:0]    low_water_copy;
    playout_t                     owed_responses [$];

    // ring depth is a power of two, so the pointer difference wraps by itself
    function automatic jbpf_pkg::ptr_t held_frames();
        return jbpf_pkg::ptr_t'(wr_ptr - rd_ptr);
    endfunction

    function automatic playout_t play_request(input jbpf_pkg::mode_t op,
                                              input logic [jbpf_pkg::SMP_W-1:0] sl,
                                              input logic [jbpf_pkg::SMP_W-1:0] sr,
                                              input logic mono, input logic fend,
                                              input logic bfirst);
        playout_t                     r;
        logic [jbpf_pkg::FRAME_W-1:0] word;
        r = '0;
        r.taken = 1'b1;
        case (op)
            jbpf_pkg::MODE_PUSH:
            begin
                if (held_frames() >= jbpf_pkg::FULL_MARK)
                begin
                    r.taken = 1'b0;
                    pushes_refused++;
                end
                else
                begin
                    ring_copy[wr_ptr] = {sl, mono ? sl : sr};
                    wr_ptr = wr_ptr + jbpf_pkg::PTR_W'(1);
                    if (fend && player_state == jbpf_pkg::ST_BUFFERING
                        && {1'b0, held_frames()} >= low_water_copy)
                        player_state = jbpf_pkg::ST_PLAYING;
                end
            end
            jbpf_pkg::MODE_PULL:
            begin
                if (bfirst)
                    block_on = (player_state == jbpf_pkg::ST_PLAYING);
                if (block_on)
                begin
                    if (held_frames() != '0)
                    begin
                        word = ring_copy[rd_ptr];
                        r.left = {word[jbpf_pkg::FRAME_W-1:jbpf_pkg::SMP_W],
                                  {jbpf_pkg::SMP_W{1'b0}}};
                        r.right = {word[jbpf_pkg::SMP_W-1:0], {jbpf_pkg::SMP_W{1'b0}}};
                        rd_ptr = rd_ptr + jbpf_pkg::PTR_W'(1);
                        frames_played++;
                    end
                    else
                    begin
                        underrun_count = underrun_count + jbpf_pkg::URUN_W'(1);
                        player_state = jbpf_pkg::ST_BUFFERING;
                        underruns_seen++;
                    end
                end
            end
            jbpf_pkg::MODE_START:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                underrun_count = '0;
                player_state = jbpf_pkg::ST_BUFFERING;
                block_on = 1'b0;
            end
            default:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                player_state = jbpf_pkg::ST_STOPPED;
                block_on = 1'b0;
            end
        endcase
        r.state = player_state;
        r.fill = jbpf_pkg::FILL_W'(held_frames());
        r.underruns = underrun_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        playout_t want;
        playout_t seen;
        if (!rst_n)
        begin
            wr_ptr = '0;
            rd_ptr = '0;
            player_state = jbpf_pkg::ST_STOPPED;
            underrun_count = '0;
            block_on = 1'b0;
            low_water_copy = jbpf_pkg::LOW_WATER_RESET;
            owed_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (low_water_we)
                low_water_copy = low_water_data;
            if (in_valid && !in_stall)
                owed_responses.push_back(play_request(jbpf_pkg::mode_t'(mode), sample_left,
                                                      sample_right, is_mono, frame_end,
                                                      block_first));
            if (out_valid && !out_stall)
            begin
                seen = {left_out, right_out, accepted, play_state, fill_level, underrun_total};
                if (owed_responses.size() == 0)
                begin
                    $error("response arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = owed_responses.pop_front();
                    check_field("left_out", want.left, seen.left);
                    check_field("right_out", want.right, seen.right);
                    check_field("accepted", 32'(want.taken), 32'(seen.taken));
                    check_field("play_state", 32'(want.state), 32'(seen.state));
                    check_field("fill_level", 32'(want.fill), 32'(seen.fill));
                    check_field("underrun_total", want.underruns, seen.underruns);
                end
            end
            outstanding <= owed_responses.size();
        end
    end

    initial
    begin
        mismatches = 0;
        frames_played = 0;
        underruns_seen = 0;
        pushes_refused = 0;
    end

endmodule

// File: verif/jitter_buffer_prebuffer_fifo_top_test.sv
// ----------------------------------------------------------------------------
// jitter_buffer_prebuffer_fifo_top_test
// Drives the jitter buffer with directed requests (stopped block, pushes
// that reach the low-water mark, underruns in a live block) and random
// playback sessions under several low-water marks, with random idling on
// both sides. A checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module jitter_buffer_prebuffer_fifo_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               low_water_we = 1'b0;
    logic [jbpf_pkg::LW_W-1:0]          low_water_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    jbpf_pkg::mode_t                    mode_sel = jbpf_pkg::MODE_PUSH;
    logic signed [jbpf_pkg::SMP_W-1:0]  sample_left = '0;
    logic signed [jbpf_pkg::SMP_W-1:0]  sample_right = '0;
    logic                               is_mono = 1'b0;
    logic                               frame_end = 1'b0;
    logic                               block_first = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [jbpf_pkg::OUT_W-1:0]  left_out;
    logic signed [jbpf_pkg::OUT_W-1:0]  right_out;
    logic                               accepted;
    logic [1:0]                         play_state;
    logic [jbpf_pkg::FILL_W-1:0]        fill_level;
    logic [jbpf_pkg::URUN_W-1:0]        underrun_total;

    int  mismatches;
    int  outstanding;
    int  frames_played;
    int  underruns_seen;
    int  pushes_refused;
    int  sent_pushes = 0;
    int  sent_pulls = 0;
    int  sent_controls = 0;
    int  low_water_writes = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;

    jitter_buffer_prebuffer_fifo_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .low_water_we   (low_water_we),
        .low_water_data (low_water_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode_sel),
        .sample_left    (sample_left),
        .sample_right   (sample_right),
        .is_mono        (is_mono),
        .frame_end      (frame_end),
        .block_first    (block_first),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_out       (left_out),
        .right_out      (right_out),
        .accepted       (accepted),
        .play_state     (play_state),
        .fill_level     (fill_level),
        .underrun_total (underrun_total)
    );

    jbpf_output_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .low_water_we   (low_water_we),
        .low_water_data (low_water_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode_sel),
        .sample_left    (sample_left),
        .sample_right   (sample_right),
        .is_mono        (is_mono),
        .frame_end      (frame_end),
        .block_first    (block_first),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_out       (left_out),
        .right_out      (right_out),
        .accepted       (accepted),
        .play_state     (play_state),
        .fill_level     (fill_level),
        .underrun_total (underrun_total),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .frames_played  (frames_played),
        .underruns_seen (underruns_seen),
        .pushes_refused (pushes_refused)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_request(input jbpf_pkg::mode_t op,
                                input logic [jbpf_pkg::SMP_W-1:0] sl,
                                input logic [jbpf_pkg::SMP_W-1:0] sr, input logic mono,
                                input logic fend, input logic bfirst);
        in_valid <= 1'b1;
        mode_sel <= op;
        sample_left <= sl;
        sample_right <= sr;
        is_mono <= mono;
        frame_end <= fend;
        block_first <= bfirst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (op)
            jbpf_pkg::MODE_PUSH: sent_pushes++;
            jbpf_pkg::MODE_PULL: sent_pulls++;
            default:             sent_controls++;
        endcase
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic push_random(input logic fend);
        send_request(jbpf_pkg::MODE_PUSH, jbpf_pkg::SMP_W'($urandom_range(0, 65535)),
                     jbpf_pkg::SMP_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     fend, 1'($urandom_range(0, 1)));
    endtask

    task automatic pull(input logic bfirst);
        send_request(jbpf_pkg::MODE_PULL, jbpf_pkg::SMP_W'($urandom_range(0, 65535)),
                     jbpf_pkg::SMP_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), bfirst);
    endtask

    task automatic control(input jbpf_pkg::mode_t op);
        send_request(op, jbpf_pkg::SMP_W'($urandom_range(0, 65535)),
                     jbpf_pkg::SMP_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // hold off until every response is back, plus the pipeline depth
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_low_water(input logic [jbpf_pkg::LW_W-1:0] level);
        settle();
        low_water_we <= 1'b1;
        low_water_data <= level;
        @(posedge clk);
        low_water_we <= 1'b0;
        low_water_writes++;
    endtask

    task automatic random_session(input int count);
        int done;
        int pick;
        int len;
        done = 1;
        control(jbpf_pkg::MODE_START);
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                control(jbpf_pkg::MODE_START);
                done++;
            end
            else if (pick < 5)
            begin
                control(jbpf_pkg::MODE_STOP);
                done++;
            end
            else if (pick < 12)
            begin
                control(jbpf_pkg::mode_t'($urandom_range(0, 3)));
                done++;
            end
            else if (pick < 55)
            begin
                // one decoded frame, occasionally missing its end mark
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    push_random(i == len - 1 && $urandom_range(0, 9) != 0);
                done += len;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    pull(i == 0);
                done += len;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stopped block, reset low-water mark
        send_request(jbpf_pkg::MODE_PULL, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(jbpf_pkg::MODE_PULL, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1);
        send_request(jbpf_pkg::MODE_PUSH, 16'h8000, 16'h7fff, 1'b0, 1'b1, 1'b0);
        control(jbpf_pkg::MODE_STOP);
        control(jbpf_pkg::MODE_START);
        send_request(jbpf_pkg::MODE_PUSH, 16'h7fff, 16'hffff, 1'b1, 1'b1, 1'b0);

        set_low_water('0);
        send_request(jbpf_pkg::MODE_PUSH, 16'h0000, 16'h8000, 1'b0, 1'b0, 1'b1);
        send_request(jbpf_pkg::MODE_PUSH, 16'hffff, 16'h0001, 1'b0, 1'b1, 1'b0);
        send_request(jbpf_pkg::MODE_PUSH, 16'h8000, 16'h7fff, 1'b1, 1'b1, 1'b0);
        pull(1'b1);
        repeat (3) pull(1'b0);
        // empty ring in a live block: two underruns back to back
        pull(1'b0);
        pull(1'b0);
        pull(1'b1);
        control(jbpf_pkg::MODE_STOP);
        control(jbpf_pkg::MODE_START);
        send_request(jbpf_pkg::MODE_PUSH, 16'h1234, 16'hedcb, 1'b0, 1'b1, 1'b0);

        for (int s = 0; s < 5; s++)
        begin
            case (s)
                1:       set_low_water(jbpf_pkg::LW_W'(1));
                2:       set_low_water(jbpf_pkg::LW_W'($urandom_range(0, jbpf_pkg::RING_DEPTH)));
                default: set_low_water(jbpf_pkg::LW_W'($urandom_range(0, 24)));
            endcase
            if (s == 4)
                calm = 1'b1;
            random_session(190);
        end

        in_valid <= 1'b0;
        fork
            begin
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
            end
        join_any
        disable fork;
        repeat (8) @(posedge clk);
        if (outstanding != 0)
            $error("%0d responses never arrived", outstanding);

        $display("requests: %0d pushes (%0d refused), %0d pulls, %0d start/stop, %0d marks",
                 sent_pushes, pushes_refused, sent_pulls, sent_controls, low_water_writes);
        $display("playback: %0d frames returned, %0d underruns", frames_played, underruns_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("jitter_buffer_prebuffer_fifo_top_test: done, clean");
        else
            $display("jitter_buffer_prebuffer_fifo_top_test: done, errors");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("jitter_buffer_prebuffer_fifo_top_test: done, errors");
        $finish;
    end

endmodule

// File: jitter_buffer_prebuffer_fifo_top.f
src/jbpf_pkg.sv
src/jbpf_ring.sv
src/jitter_buffer_prebuffer_fifo_top.sv
src/jbpf_checker.sv
verif/jbpf_output_checker.sv
verif/jitter_buffer_prebuffer_fifo_top_test.sv
